>>> rtl/core/hbkd_pkg.sv
// ----------------------------------------------------------------------------
// hbkd_pkg
// Types, constants and the usage-to-ASCII translation of the boot keyboard
// report differ.
// ----------------------------------------------------------------------------
package hbkd_pkg;

  localparam int unsigned MaxSlots = 6;

  localparam logic [7:0] UsageArrowUp    = 8'h52;
  localparam logic [7:0] UsageArrowDown  = 8'h51;
  localparam logic [7:0] UsageArrowLeft  = 8'h50;
  localparam logic [7:0] UsageArrowRight = 8'h4F;
  localparam logic [7:0] UsageEnter      = 8'h28;
  localparam logic [7:0] UsageBackspace  = 8'h2A;
  localparam logic [7:0] UsageSpace      = 8'h2C;
  localparam logic [7:0] UsageFirstAlpha = 8'h04;
  localparam logic [7:0] UsageLastAlpha  = 8'h1D;
  localparam logic [7:0] UsageFirstDigit = 8'h1E;
  localparam logic [7:0] UsageLastMapped = 8'h38;
  localparam logic [7:0] ModShiftMask    = 8'h22;
  localparam logic [6:0] CharUnknown     = 7'h3F;

  localparam logic EventPress   = 1'b0;
  localparam logic EventRelease = 1'b1;

  typedef struct packed {
    logic [7:0] modifier_keys;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
  } hbkd_in_t;

  typedef struct packed {
    logic [7:0] key_usage;
    logic       event_kind;
    logic [7:0] modifier_state;
    logic [6:0] ascii_char;
    logic       arrow_up;
    logic       arrow_down;
    logic       arrow_left;
    logic       arrow_right;
    logic       last_event;
  } hbkd_out_t;

  // Translate a usage code to ASCII; shift applies when either shift bit is set.
  function automatic logic [6:0] hbkd_to_ascii(input logic [7:0] usage,
                                               input logic [7:0] mods);
    logic       shift;
    logic [6:0] offs;
    logic [6:0] ch;
    shift = |(mods & ModShiftMask);
    offs  = 7'(usage - UsageFirstAlpha);
    ch    = CharUnknown;
    case (usage) inside
      [UsageFirstAlpha:UsageLastAlpha]: ch = offs + (shift ? 7'h41 : 7'h61);
      8'h1E: ch = shift ? 7'h21 : 7'h31;
      8'h1F: ch = shift ? 7'h40 : 7'h32;
      8'h20: ch = shift ? 7'h23 : 7'h33;
      8'h21: ch = shift ? 7'h24 : 7'h34;
      8'h22: ch = shift ? 7'h25 : 7'h35;
      8'h23: ch = shift ? 7'h5E : 7'h36;
      8'h24: ch = shift ? 7'h26 : 7'h37;
      8'h25: ch = shift ? 7'h2A : 7'h38;
      8'h26: ch = shift ? 7'h28 : 7'h39;
      8'h27: ch = shift ? 7'h29 : 7'h30;
      UsageEnter:     ch = 7'h0A;
      UsageBackspace: ch = 7'h08;
      UsageSpace:     ch = 7'h20;
      8'h2D: ch = shift ? 7'h5F : 7'h2D;
      8'h2E: ch = shift ? 7'h2B : 7'h3D;
      8'h2F: ch = shift ? 7'h7B : 7'h5B;
      8'h30: ch = shift ? 7'h7D : 7'h5D;
      8'h31: ch = shift ? 7'h7C : 7'h5C;
      8'h33: ch = shift ? 7'h3A : 7'h3B;
      8'h34: ch = shift ? 7'h22 : 7'h27;
      8'h35: ch = shift ? 7'h7E : 7'h60;
      8'h36: ch = shift ? 7'h3C : 7'h2C;
      8'h37: ch = shift ? 7'h3E : 7'h2E;
      UsageLastMapped: ch = shift ? 7'h3F : 7'h2F;
      default: ch = CharUnknown;
    endcase
    return ch;
  endfunction

endpackage

>>> rtl/core/hid_boot_keyboard_report_differ.sv
// ----------------------------------------------------------------------------
// hid_boot_keyboard_report_differ
// Compares each boot keyboard report against the previous one and emits
// press events, then release events, one item per change.
// ----------------------------------------------------------------------------
//  channel | direction | payload     | handshake
//  in      | input     | hbkd_in_t   | in_valid_i / in_ready_o
//  out     | output    | hbkd_out_t  | out_valid_o / out_ready_i
//
// A report is scanned one candidate key per cycle through the shared compare
// unit, then its events go out one per cycle while the output is taken, and a
// closing step copies the current keys into the previous ones. Reset clears
// the previous key slots and the sequencer. A stalled output holds its item;
// the input is taken again only once the sequencer is idle.
// ----------------------------------------------------------------------------
module hid_boot_keyboard_report_differ import hbkd_pkg::*; #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  hbkd_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output hbkd_out_t out_data_o
);

  localparam int unsigned MaskW = 2 * KEY_SLOTS;
  localparam int unsigned IdxW  = (MaskW > 1) ? $clog2(MaskW) : 1;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StEmit
  } state_e;

  state_e     state_q;
  logic [IdxW-1:0] idx_q;
  logic [MaskW-1:0] mask_q;
  logic [7:0] cur_q  [KEY_SLOTS];
  logic [7:0] prev_q [KEY_SLOTS];
  logic [7:0] mods_q;
  logic [3:0] arrows_q;
  logic       out_valid_q;
  hbkd_out_t  out_q;

  logic [7:0] in_slots [MaxSlots];
  logic [3:0] arrows_d;
  logic [7:0] cand;
  logic [7:0] other [KEY_SLOTS];
  logic       hit;
  logic [IdxW-1:0] sel;
  logic [MaskW-1:0] rest;
  logic [7:0] emit_key;
  logic       emit_go;

  assign in_slots[0] = in_data_i.key_slot_0;
  assign in_slots[1] = in_data_i.key_slot_1;
  assign in_slots[2] = in_data_i.key_slot_2;
  assign in_slots[3] = in_data_i.key_slot_3;
  assign in_slots[4] = in_data_i.key_slot_4;
  assign in_slots[5] = in_data_i.key_slot_5;

  // Arrow flags {up, down, left, right} over the used slots only.
  always_comb begin
    arrows_d = 4'b0000;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if (in_slots[j] == UsageArrowUp)    arrows_d[3] = 1'b1;
      if (in_slots[j] == UsageArrowDown)  arrows_d[2] = 1'b1;
      if (in_slots[j] == UsageArrowLeft)  arrows_d[1] = 1'b1;
      if (in_slots[j] == UsageArrowRight) arrows_d[0] = 1'b1;
    end
  end

  // Candidates below KEY_SLOTS are current keys checked against the previous
  // report; the upper half are previous keys checked against the current one.
  always_comb begin
    cand = 8'h00;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if (idx_q == IdxW'(j))             cand = cur_q[j];
      if (idx_q == IdxW'(j + KEY_SLOTS)) cand = prev_q[j];
      other[j] = (idx_q < IdxW'(KEY_SLOTS)) ? prev_q[j] : cur_q[j];
    end
  end

  hbkd_key_cmp #(
    .KEY_SLOTS(KEY_SLOTS)
  ) u_key_cmp (
    .cand_i (cand),
    .other_i(other),
    .hit_o  (hit)
  );

  // Lowest pending event and the key it refers to.
  always_comb begin
    sel = '0;
    for (int j = MaskW - 1; j >= 0; j--) begin
      if (mask_q[j]) sel = IdxW'(j);
    end
    rest = mask_q & ~(MaskW'(1) << sel);
    emit_key = 8'h00;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if (sel == IdxW'(j))             emit_key = cur_q[j];
      if (sel == IdxW'(j + KEY_SLOTS)) emit_key = prev_q[j];
    end
  end

  // A new event is loaded when one is pending and the output slot is free.
  assign emit_go = (state_q == StEmit) && (mask_q != '0) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      mask_q      <= '0;
      mods_q      <= '0;
      arrows_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        cur_q[j]  <= '0;
        prev_q[j] <= '0;
      end
    end else begin
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            for (int j = 0; j < KEY_SLOTS; j++) begin
              cur_q[j] <= in_slots[j];
            end
            mods_q   <= in_data_i.modifier_keys;
            arrows_q <= arrows_d;
            idx_q    <= '0;
            state_q  <= StScan;
          end
        end
        StScan: begin
          mask_q[idx_q] <= hit;
          if (idx_q == IdxW'(MaskW - 1)) begin
            state_q <= StEmit;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        StEmit: begin
          if (mask_q == '0) begin
            for (int j = 0; j < KEY_SLOTS; j++) begin
              prev_q[j] <= cur_q[j];
            end
            state_q <= StIdle;
          end else if (emit_go) begin
            out_q.key_usage      <= emit_key;
            out_q.event_kind     <= (sel < IdxW'(KEY_SLOTS)) ? EventPress : EventRelease;
            out_q.modifier_state <= mods_q;
            out_q.ascii_char     <= hbkd_to_ascii(emit_key, mods_q);
            out_q.arrow_up       <= arrows_q[3];
            out_q.arrow_down     <= arrows_q[2];
            out_q.arrow_left     <= arrows_q[1];
            out_q.arrow_right    <= arrows_q[0];
            out_q.last_event     <= (rest == '0);
            mask_q               <= rest;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/core/hbkd_key_cmp.sv
// ----------------------------------------------------------------------------
// hbkd_key_cmp
// Shared compare unit: flags a nonzero candidate key that is absent from a
// set of key slots.
// ----------------------------------------------------------------------------
module hbkd_key_cmp import hbkd_pkg::*; #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic [7:0] cand_i,
  input  logic [7:0] other_i [KEY_SLOTS],
  output logic       hit_o
);

  logic held;

  always_comb begin
    held = 1'b0;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if (other_i[j] == cand_i) begin
        held = 1'b1;
      end
    end
  end

  assign hit_o = (cand_i != 8'h00) && !held;

endmodule

>>> rtl/core/hbkd_checker.sv
// ----------------------------------------------------------------------------
// hbkd_checker
// Port-level checks of the report differ, bound to the top level.
// ----------------------------------------------------------------------------
module hbkd_checker import hbkd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input hbkd_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input hbkd_out_t out_data_o
);

  // A stalled result item keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output item changed");

  // Each report is scanned before another one is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after an item");

  // Events always name a real key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.key_usage != 8'h00)
    else $error("event with empty usage");

  // Enter translates to newline regardless of shift.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.key_usage == UsageEnter |-> out_data_o.ascii_char == 7'h0A)
    else $error("enter not translated to newline");

endmodule

bind hid_boot_keyboard_report_differ hbkd_checker u_hbkd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

>>> tb/tb_hid_boot_keyboard_report_differ.sv
// ----------------------------------------------------------------------------
// tb_hid_boot_keyboard_report_differ
// Feeds boot keyboard reports through the differ with random gaps on the
// report side and random stalls on the event side. A local model of the key
// tracking predicts the press and release events of each accepted report,
// and every event taken from the block is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hid_boot_keyboard_report_differ;
  import hbkd_pkg::*;

  localparam int unsigned Slots       = 6;
  localparam int unsigned RandReports = 190;
  localparam int unsigned DrainCycles = 40;

  typedef logic [Slots-1:0][7:0] key_set_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i;
  logic      in_ready_o;
  hbkd_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  hbkd_out_t out_data_o;

  hbkd_in_t  pending_reports[$];
  hbkd_out_t expected_events[$];
  key_set_t  held_keys;
  int        send_gap;
  int        stall_left;
  int        fails;
  logic      calm;

  hid_boot_keyboard_report_differ #(
    .KEY_SLOTS(Slots)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Control keys do not depend on shift; the placeholders in the tables
  // below stand at the positions of usages without a character and give '?'.
  function automatic logic [6:0] usage_char(input logic [7:0] usage, input logic [7:0] mods);
    string plain;
    string shifted;
    int    idx;
    plain   = {"abcdefghijklmnopqrstuvwxyz", "1234567890", "?????", "-=[]\\?;'`,./"};
    shifted = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ", "!@#$%^&*()", "?????", "_+{}|?:\"~<>?"};
    if (usage < UsageFirstAlpha || usage > UsageLastMapped) begin
      return CharUnknown;
    end
    if (usage == UsageEnter) begin
      return 7'h0A;
    end
    if (usage == UsageBackspace) begin
      return 7'h08;
    end
    if (usage == UsageSpace) begin
      return 7'h20;
    end
    idx = int'(usage) - int'(UsageFirstAlpha);
    if ((mods & ModShiftMask) != 8'h00) begin
      return 7'(shifted[idx]);
    end
    return 7'(plain[idx]);
  endfunction

  function automatic logic holds_key(input key_set_t keys, input logic [7:0] key);
    for (int i = 0; i < Slots; i++) begin
      if (keys[i] == key) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Works out the events of one accepted report and advances the key memory.
  key_set_t prior_keys;

  task automatic predict_report(input hbkd_in_t rpt);
    key_set_t  cur;
    key_set_t  scan;
    key_set_t  other;
    hbkd_out_t ev;
    hbkd_out_t batch[$];
    logic      up, down, left, right;
    cur = {rpt.key_slot_5, rpt.key_slot_4, rpt.key_slot_3,
           rpt.key_slot_2, rpt.key_slot_1, rpt.key_slot_0};
    up    = holds_key(cur, UsageArrowUp);
    down  = holds_key(cur, UsageArrowDown);
    left  = holds_key(cur, UsageArrowLeft);
    right = holds_key(cur, UsageArrowRight);
    for (int pass = 0; pass < 2; pass++) begin
      scan  = (pass == 0) ? cur : prior_keys;
      other = (pass == 0) ? prior_keys : cur;
      for (int i = 0; i < Slots; i++) begin
        if (scan[i] != 8'h00 && !holds_key(other, scan[i])) begin
          ev.key_usage      = scan[i];
          ev.event_kind     = (pass == 0) ? EventPress : EventRelease;
          ev.modifier_state = rpt.modifier_keys;
          ev.ascii_char     = usage_char(scan[i], rpt.modifier_keys);
          ev.arrow_up       = up;
          ev.arrow_down     = down;
          ev.arrow_left     = left;
          ev.arrow_right    = right;
          ev.last_event     = 1'b0;
          batch.push_back(ev);
        end
      end
    end
    if (batch.size() != 0) begin
      batch[batch.size() - 1].last_event = 1'b1;
    end
    foreach (batch[i]) begin
      expected_events.push_back(batch[i]);
    end
    prior_keys = cur;
  endtask

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) begin
      return 0;
    end
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 8'($urandom_range(32'h04, 32'h38));
    end
    if (r < 85) begin
      return 8'($urandom_range(32'h4F, 32'h52));
    end
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic hbkd_in_t make_report(input logic [7:0] mods, input key_set_t keys);
    hbkd_in_t rpt;
    rpt.modifier_keys = mods;
    rpt.key_slot_0    = keys[0];
    rpt.key_slot_1    = keys[1];
    rpt.key_slot_2    = keys[2];
    rpt.key_slot_3    = keys[3];
    rpt.key_slot_4    = keys[4];
    rpt.key_slot_5    = keys[5];
    return rpt;
  endfunction

  task automatic add_report(input logic [7:0] mods, input key_set_t keys);
    pending_reports.push_back(make_report(mods, keys));
  endtask

  // Mostly a keyboard that presses, releases and swaps a few keys at a time,
  // with noise reports and repeats mixed in.
  task automatic add_random_reports(input int count);
    logic [7:0] mods;
    hbkd_in_t   noise;
    int         r;
    int         slot;
    mods      = 8'h00;
    held_keys = '0;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        noise = hbkd_in_t'({$urandom(), 24'($urandom())});
        pending_reports.push_back(noise);
      end else if (r < 25) begin
        if ($urandom_range(0, 1) == 0) begin
          mods = 8'($urandom());
        end
        add_report(mods, held_keys);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          slot = $urandom_range(0, Slots - 1);
          if (held_keys[slot] == 8'h00 || $urandom_range(0, 3) == 0) begin
            held_keys[slot] = pick_key();
          end else begin
            held_keys[slot] = 8'h00;
          end
        end
        if ($urandom_range(0, 9) < 3) begin
          case ($urandom_range(0, 4))
            0: mods = 8'h00;
            1: mods = 8'h02;
            2: mods = 8'h20;
            3: mods = 8'h22;
            default: mods = 8'($urandom());
          endcase
        end
        add_report(mods, held_keys);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calm <= 1'b0;
    end else if ($urandom_range(0, 199) == 0) begin
      calm <= ~calm;
    end
  end

  // Report driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_report(in_data_i);
      end
      if (in_valid_i && !in_ready_o) begin
        // Hold the item until it is taken.
      end else if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap   <= send_gap - 1;
      end else if (pending_reports.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_reports.pop_front();
        send_gap   <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fails++;
    end
  endtask

  // Event monitor and output stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    hbkd_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event, expected none, actual %h", $time, out_data_o);
          fails++;
        end else begin
          want = expected_events.pop_front();
          check_field("key_usage", want.key_usage, out_data_o.key_usage);
          check_field("event_kind", 8'(want.event_kind), 8'(out_data_o.event_kind));
          check_field("modifier_state", want.modifier_state, out_data_o.modifier_state);
          check_field("ascii_char", 8'(want.ascii_char), 8'(out_data_o.ascii_char));
          check_field("arrow_up", 8'(want.arrow_up), 8'(out_data_o.arrow_up));
          check_field("arrow_down", 8'(want.arrow_down), 8'(out_data_o.arrow_down));
          check_field("arrow_left", 8'(want.arrow_left), 8'(out_data_o.arrow_left));
          check_field("arrow_right", 8'(want.arrow_right), 8'(out_data_o.arrow_right));
          check_field("last_event", 8'(want.last_event), 8'(out_data_o.last_event));
        end
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left  <= stall_left - 1;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 2) == 0) begin
          stall_left <= pick_gap();
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("tb_hid_boot_keyboard_report_differ: errors");
    $finish;
  end

  initial begin
    fails      = 0;
    prior_keys = '0;
    // Directed reports; slot 0 is the rightmost byte of each key list.
    add_report(8'h00, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    add_report(8'h00, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04});
    add_report(8'h02, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04});
    add_report(8'h20, {8'h00, 8'h00, 8'h00, 8'h00, 8'h1D, 8'h04});
    add_report(8'h00, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    // Control keys and unmapped usages inside the table.
    add_report(8'h00, {8'h32, 8'h2B, 8'h29, 8'h2C, 8'h2A, 8'h28});
    add_report(8'h22, {8'h2C, 8'h2A, 8'h28, 8'h32, 8'h2B, 8'h29});
    // Six new keys against six old ones: twelve events.
    add_report(8'h22, {8'h23, 8'h22, 8'h21, 8'h20, 8'h1F, 8'h1E});
    add_report(8'h02, {8'h2E, 8'h2D, 8'h27, 8'h26, 8'h25, 8'h24});
    add_report(8'h20, {8'h35, 8'h34, 8'h33, 8'h31, 8'h30, 8'h2F});
    add_report(8'h00, {8'h35, 8'h34, 8'h33, 8'h31, 8'h30, 8'h2F});
    add_report(8'h00, {8'h00, 8'h03, 8'h39, 8'h38, 8'h37, 8'h36});
    add_report(8'h22, {8'h00, 8'h03, 8'h39, 8'h38, 8'h37, 8'h36});
    add_report(8'h22, {8'h00, 8'h00, 8'h00, 8'h38, 8'h37, 8'h36});
    add_report(8'hFF, {8'h00, 8'h00, 8'h4F, 8'h50, 8'h51, 8'h52});
    add_report(8'hDD, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h52});
    // Repeated usages within one report, for presses and then releases.
    add_report(8'h01, {8'h00, 8'hFF, 8'h02, 8'h01, 8'hFF, 8'hFF});
    add_report(8'h00, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    add_report(8'h80, {8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05});
    add_report(8'h40, {8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    add_report(8'hFF, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    add_report(8'hFF, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    add_report(8'h00, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    add_random_reports(RandReports);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_reports.size() == 0 && !in_valid_i);
    wait (expected_events.size() == 0);
    // A report without events may still be in the scan when the queue empties.
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_events.size() != 0) begin
      $display("%0t: %0d events never arrived, expected %h, actual none",
               $time, expected_events.size(), expected_events[0]);
      fails++;
    end
    if (fails == 0) begin
      $display("tb_hid_boot_keyboard_report_differ: clean");
    end else begin
      $display("tb_hid_boot_keyboard_report_differ: errors");
    end
    $finish;
  end

endmodule
